FILE: design/modular_power_square_multiply_top_defines.svh
// Assertion macros shared by the modular power block
`ifndef MODULAR_POWER_SQUARE_MULTIPLY_TOP_DEFINES_SVH
`define MODULAR_POWER_SQUARE_MULTIPLY_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define MPSM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define MPSM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/mpsm_pkg.sv
package mpsm_pkg;

  // Operand width of base, exponent, modulus and result
  localparam int OPERAND_BITS = 31;
  localparam int CNT_W        = $clog2(OPERAND_BITS);

  localparam logic [OPERAND_BITS-1:0] MODULUS_RESET = OPERAND_BITS'(9999991);

  // Operation codes for the shared modular multiplier
  localparam logic [1:0] OP_RED = 2'd0;  // base mod m
  localparam logic [1:0] OP_MUL = 2'd1;  // acc * sq mod m
  localparam logic [1:0] OP_SQR = 2'd2;  // sq * sq mod m

  // Controller to datapath commands
  typedef struct packed {
    logic       load;      // capture exponent, init accumulator
    logic       start;     // start a modular multiply
    logic [1:0] op;        // which multiply
    logic       shift_e;   // drop the exponent lsb
    logic       load_out;  // capture result into output register
  } mpsm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic mul_done;  // last step of the multiply this cycle
    logic e_lsb;     // current exponent bit
    logic e_zero;    // no set bits left in the exponent
    logic m_small;   // modulus below two
  } mpsm_stat_t;

endpackage

FILE: design/mpsm_datapath.sv
module mpsm_datapath
  import mpsm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [OPERAND_BITS-1:0] cfg_data,
  input  logic [OPERAND_BITS-1:0] in_base_value,
  input  logic [OPERAND_BITS-1:0] in_exponent,
  input  mpsm_cmd_t               cmd_i,
  output mpsm_stat_t              stat_o,
  output logic [OPERAND_BITS-1:0] out_power_mod
);

  `include "modular_power_square_multiply_top_defines.svh"

  localparam int W = OPERAND_BITS;

  logic [W-1:0]     m_r;
  logic [W-1:0]     e_r, e_nxt;
  logic [W-1:0]     acc_r, acc_nxt;
  logic [W-1:0]     sq_r, sq_nxt;
  logic [W-1:0]     x_r, x_nxt;
  logic [W-1:0]     y_r, y_nxt;
  logic [W-1:0]     r_r, r_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       op_r, op_nxt;
  logic             busy_r, busy_nxt;
  logic [W-1:0]     res_r;

  logic [W+1:0]     t_sum, m1_ext, m2_ext, t_red;
  logic [W-1:0]     step_val;
  logic             done;
  logic             m_small;

  // Modulus register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r <= MODULUS_RESET;
    end else if (cfg_we) begin
      m_r <= cfg_data;
    end
  end

  assign m_small = (m_r[W-1:1] == '0);

  // One interleaved multiply step: r = (2r + bit*y) mod m, with r, y < m
  always_comb begin
    m1_ext = {2'b00, m_r};
    m2_ext = {1'b0, m_r, 1'b0};
    t_sum  = {1'b0, r_r, 1'b0} + {2'b00, (x_r[W-1] ? y_r : '0)};
    if (t_sum >= m2_ext) begin
      t_red = t_sum - m2_ext;
    end else if (t_sum >= m1_ext) begin
      t_red = t_sum - m1_ext;
    end else begin
      t_red = t_sum;
    end
    step_val = t_red[W-1:0];
  end

  assign done = busy_r && (cnt_r == '0);

  // Multiplier sequencing and operand registers
  always_comb begin
    e_nxt    = e_r;
    acc_nxt  = acc_r;
    sq_nxt   = sq_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    r_nxt    = r_r;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    busy_nxt = busy_r;

    if (cmd_i.load) begin
      e_nxt   = in_exponent;
      acc_nxt = {{(W-1){1'b0}}, !m_small};
    end
    if (cmd_i.shift_e) begin
      e_nxt = {1'b0, e_r[W-1:1]};
    end

    // step the running multiply, write back on the last step
    if (busy_r) begin
      r_nxt   = step_val;
      x_nxt   = {x_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (done) begin
        busy_nxt = 1'b0;
        if (op_r == OP_MUL) begin
          acc_nxt = step_val;
        end else begin
          sq_nxt = step_val;
        end
      end
    end

    // a start overrides the multiplier state; a finishing result is still written back
    if (cmd_i.start) begin
      busy_nxt = 1'b1;
      op_nxt   = cmd_i.op;
      r_nxt    = '0;
      cnt_nxt  = CNT_W'(OPERAND_BITS - 1);
      case (cmd_i.op)
        OP_RED: begin
          x_nxt = in_base_value;
          y_nxt = {{(W-1){1'b0}}, 1'b1};
        end
        OP_MUL: begin
          x_nxt = acc_r;
          y_nxt = sq_r;
        end
        default: begin
          x_nxt = sq_r;
          y_nxt = sq_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r   <= e_nxt;
    acc_r <= acc_nxt;
    sq_r  <= sq_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    r_r   <= r_nxt;
    cnt_r <= cnt_nxt;
    op_r  <= op_nxt;
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (cmd_i.load_out) begin
      res_r <= acc_r;
    end
  end

  assign out_power_mod   = res_r;
  assign stat_o.mul_done = done;
  assign stat_o.e_lsb    = e_r[0];
  assign stat_o.e_zero   = (e_r == '0);
  assign stat_o.m_small  = m_small;

  `MPSM_ASSERT_IMP(a_no_restart, cmd_i.start, !busy_r || done,
    "multiply started while previous one still running")
  `MPSM_ASSERT_IMP(a_partial_range, busy_r, r_r < m_r,
    "partial remainder not below modulus")
  `MPSM_ASSERT_IMP(a_acc_range, busy_r, acc_r < m_r,
    "accumulator not reduced during computation")

endmodule

FILE: design/mpsm_ctrl.sv
module mpsm_ctrl
  import mpsm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  mpsm_stat_t stat_i,
  output mpsm_cmd_t  cmd_o
);

  `include "modular_power_square_multiply_top_defines.svh"

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RED    = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_SQR    = 3'd4;
  localparam logic [2:0] ST_OUT    = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall = (state_r != ST_IDLE);

  // Sequencer: reduce base, then per exponent bit a square, preceded by a multiply when the bit is set
  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    cmd_o.op  = OP_RED;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_o.load = 1'b1;
          if (stat_i.m_small) begin
            state_nxt = ST_OUT;
          end else begin
            cmd_o.start = 1'b1;
            cmd_o.op    = OP_RED;
            state_nxt   = ST_RED;
          end
        end
      end
      ST_RED: begin
        if (stat_i.mul_done) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat_i.e_zero) begin
          state_nxt = ST_OUT;
        end else if (stat_i.e_lsb) begin
          cmd_o.start = 1'b1;
          cmd_o.op    = OP_MUL;
          state_nxt   = ST_MUL;
        end else begin
          cmd_o.start = 1'b1;
          cmd_o.op    = OP_SQR;
          state_nxt   = ST_SQR;
        end
      end
      ST_MUL: begin
        if (stat_i.mul_done) begin
          cmd_o.start = 1'b1;
          cmd_o.op    = OP_SQR;
          state_nxt   = ST_SQR;
        end
      end
      ST_SQR: begin
        if (stat_i.mul_done) begin
          cmd_o.shift_e = 1'b1;
          state_nxt     = ST_DECIDE;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd_o.load_out = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on a new result, cleared after a transfer
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd_o.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `MPSM_ASSERT_NXT(a_accept_busy, in_valid && !in_stall, state_r != ST_IDLE,
    "accepted transfer did not start a computation")
  `MPSM_ASSERT_IMP(a_decide_idle_unit, state_r == ST_DECIDE, !stat_i.mul_done,
    "multiplier still running while deciding next step")

endmodule

FILE: design/modular_power_square_multiply_top.sv
// Modular power, right-to-left square-and-multiply on one shared
// bit-serial modular multiplier (one product bit per cycle).
// Base is reduced first, then per exponent bit up to the highest set bit a square,
// preceded by a multiply when the bit is set; input stalls until the controller is idle.
// Result sits in an output register, so the next item runs while it waits.
// rst_n is synchronous, active low; modulus resets to 9999991.
module modular_power_square_multiply_top
  import mpsm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [OPERAND_BITS-1:0] cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OPERAND_BITS-1:0] in_base_value,
  input  logic [OPERAND_BITS-1:0] in_exponent,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [OPERAND_BITS-1:0] out_power_mod
);

  mpsm_cmd_t  cmd;
  mpsm_stat_t stat;

  // Controller
  mpsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // Datapath with modulus register and shared multiplier
  mpsm_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_base_value (in_base_value),
    .in_exponent   (in_exponent),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_power_mod (out_power_mod)
  );

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import mpsm_pkg::*;

  typedef logic [OPERAND_BITS-1:0] word_t;

  // Which side backs off, per phase of the run
  typedef enum int {IDLE_RX_HEAVY, IDLE_TX_HEAVY, IDLE_NONE} idle_mode_t;

  // One row of the directed table; power is only used when known is set
  typedef struct packed {
    word_t modulus;
    word_t base;
    word_t exponent;
    logic  known;
    word_t power;
  } vector_t;

  localparam word_t ALL_ONES        = '1;
  localparam int    BLOCKS          = 12;
  localparam int    ITEMS_PER_BLOCK = 22;
  localparam int    SETTLE_CYCLES   = 40;
  localparam int    WATCHDOG_LIMIT  = 20000;

  logic  clk = 1'b0;
  logic  rst_n;
  logic  cfg_we;
  word_t cfg_data;
  logic  in_valid;
  logic  in_stall;
  word_t in_base_value;
  word_t in_exponent;
  logic  out_valid;
  logic  out_stall = 1'b0;
  word_t out_power_mod;

  word_t   expected_powers[$];
  vector_t vectors[$];
  word_t   cur_modulus = MODULUS_RESET;
  word_t   want;
  int      tx_idle_pct = 0;
  int      rx_idle_pct = 0;
  int      mismatch_count = 0;
  int      quiet_cycles = 0;

  modular_power_square_multiply_top uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_base_value (in_base_value),
    .in_exponent   (in_exponent),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_power_mod (out_power_mod)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Right-to-left square-and-multiply; 62-bit products fit in 64 bits
  function automatic word_t power_mod_of(input word_t b, input word_t e, input word_t m);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [63:0] mm;
    if (m == '0) return '0;
    mm  = 64'(m);
    acc = 64'd1 % mm;
    sq  = 64'(b) % mm;
    for (int i = 0; i < OPERAND_BITS; i++) begin
      if (e[i]) acc = (acc * sq) % mm;
      sq = (sq * sq) % mm;
    end
    return acc[OPERAND_BITS-1:0];
  endfunction

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_RX_HEAVY: begin
        tx_idle_pct = 18;
        rx_idle_pct = 47;
      end
      IDLE_TX_HEAVY: begin
        tx_idle_pct = 47;
        rx_idle_pct = 18;
      end
      default: begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
    endcase
  endtask

  task automatic add_vector(input word_t m, input word_t b, input word_t e,
                            input logic known, input word_t power);
    vector_t v;
    v.modulus  = m;
    v.base     = b;
    v.exponent = e;
    v.known    = known;
    v.power    = power;
    vectors.push_back(v);
  endtask

  // Present one item, hold it through stalls, record its expected power
  task automatic send_power(input word_t b, input word_t e, input logic known,
                            input word_t power);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_base_value <= b;
    in_exponent   <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_powers.push_back(known ? power : power_mod_of(b, e, cur_modulus));
  endtask

  // Stop sending and wait until every result has been taken
  task automatic drain_block();
    in_valid <= 1'b0;
    while (expected_powers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_modulus(input word_t m);
    drain_block();
    cfg_we   <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we      <= 1'b0;
    cur_modulus = m;
  endtask

  // Result checker and receiver back-pressure
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_powers.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected power_mod transfer, expected none, actual %0d",
                 $time, out_power_mod);
      end else begin
        want = expected_powers.pop_front();
        if (out_power_mod !== want) begin
          mismatch_count++;
          $display("%0t: power_mod mismatch, expected %0d, actual %0d",
                   $time, want, out_power_mod);
        end
      end
    end
    out_stall <= rst_n && ($urandom_range(0, 99) < rx_idle_pct);
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int    sel;
    word_t b;
    word_t e;

    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    in_base_value <= '0;
    in_exponent   <= '0;

    // Reset modulus: zero exponent, bases of zero, one, modulus and minus one, and mixed cases
    add_vector(MODULUS_RESET, '0, '0, 1'b1, 31'd1);
    add_vector(MODULUS_RESET, 31'd12345, '0, 1'b1, 31'd1);
    add_vector(MODULUS_RESET, '0, 31'd5, 1'b1, '0);
    add_vector(MODULUS_RESET, 31'd1, ALL_ONES, 1'b1, 31'd1);
    add_vector(MODULUS_RESET, 31'd2, 31'd10, 1'b1, 31'd1024);
    add_vector(MODULUS_RESET, MODULUS_RESET, 31'd7, 1'b1, '0);
    add_vector(MODULUS_RESET, MODULUS_RESET - 31'd1, 31'd2, 1'b1, 31'd1);
    add_vector(MODULUS_RESET, MODULUS_RESET - 31'd1, 31'd3, 1'b1, MODULUS_RESET - 31'd1);
    add_vector(MODULUS_RESET, ALL_ONES, ALL_ONES, 1'b0, '0);
    add_vector(MODULUS_RESET, 31'd3, 31'd1, 1'b1, 31'd3);
    // Largest modulus
    add_vector(ALL_ONES, ALL_ONES, 31'd5, 1'b1, '0);
    add_vector(ALL_ONES, ALL_ONES - 31'd1, ALL_ONES, 1'b1, ALL_ONES - 31'd1);
    add_vector(ALL_ONES, 31'd2, 31'd31, 1'b1, 31'd1);
    add_vector(ALL_ONES, 31'd123456789, 31'd1000, 1'b0, '0);
    add_vector(ALL_ONES, '0, '0, 1'b1, 31'd1);
    // Smallest legal modulus
    add_vector(31'd2, ALL_ONES, ALL_ONES, 1'b1, 31'd1);
    add_vector(31'd2, ALL_ONES - 31'd1, 31'd3, 1'b1, '0);
    add_vector(31'd2, 31'd5, '0, 1'b1, 31'd1);
    // Modulus of one and of zero both give zero
    add_vector(31'd1, 31'd7, '0, 1'b1, '0);
    add_vector(31'd1, ALL_ONES, ALL_ONES, 1'b1, '0);
    add_vector('0, 31'd5, 31'd3, 1'b1, '0);
    add_vector('0, '0, '0, 1'b1, '0);
    // Small odd modulus
    add_vector(31'd3, 31'd2, ALL_ONES, 1'b1, 31'd2);
    add_vector(31'd3, 31'd1234567, 31'd65535, 1'b0, '0);

    set_idling(IDLE_RX_HEAVY);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (vectors[i]) begin
      if (vectors[i].modulus != cur_modulus) write_modulus(vectors[i].modulus);
      send_power(vectors[i].base, vectors[i].exponent, vectors[i].known,
                 vectors[i].power);
    end

    // Random blocks, each under a fresh modulus
    for (int blk = 0; blk < BLOCKS; blk++) begin
      case (blk)
        0:       write_modulus(ALL_ONES);
        1:       write_modulus(31'd2);
        2:       write_modulus(MODULUS_RESET);
        3:       write_modulus(word_t'($urandom_range(3, 1000)));
        default: write_modulus(word_t'($urandom_range(2, 32'h7FFF_FFFF)));
      endcase
      if (blk < 4)      set_idling(IDLE_RX_HEAVY);
      else if (blk < 8) set_idling(IDLE_TX_HEAVY);
      else              set_idling(IDLE_NONE);

      for (int n = 0; n < ITEMS_PER_BLOCK; n++) begin
        sel = $urandom_range(0, 9);
        case (sel)
          0:       b = '0;
          1:       b = cur_modulus - 31'd1;
          2:       b = cur_modulus;
          3:       b = word_t'($urandom_range(0, 15));
          default: b = word_t'($urandom);
        endcase
        // Mostly short exponents to keep the run fast
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
          e = word_t'($urandom_range(0, 255));
        end else if (sel < 9) begin
          e = word_t'($urandom);
        end else begin
          case ($urandom_range(0, 3))
            0:       e = '0;
            1:       e = 31'd1;
            2:       e = ALL_ONES;
            default: e = word_t'(1) << (OPERAND_BITS - 1);
          endcase
        end
        send_power(b, e, 1'b0, '0);
      end
    end

    drain_block();
    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/mpsm_pkg.sv
design/mpsm_datapath.sv
design/mpsm_ctrl.sv
design/modular_power_square_multiply_top.sv
dv/tb_top.sv
